// File: hdl/prewitt_edge_magnitude_assert.svh
// ---------------------------------------------------------------------------
// prewitt edge magnitude assertion macros
// shared property forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_ASSERT_SVH
`define PREWITT_EDGE_MAGNITUDE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PEM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pem check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pem check failed");

`endif

// File: hdl/pem_pkg.sv
// ---------------------------------------------------------------------------
// pem_pkg
// widths, constants and shared types of the prewitt edge magnitude block
// ---------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

  localparam int PIX_W      = 8;
  localparam int GREY_W     = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int SUM_W      = 10;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int RAD_W      = 21;
  localparam int ROOT_W     = 11;
  localparam int CNT_W      = $clog2(ROOT_W);
  localparam int WIN_N      = 9;

  // floor(x/3) for x <= 765 as (x*683) >> 11
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD3_W    = 20;

  localparam int EDGE_MAX        = 255;
  localparam int MIN_DIM         = 3;
  localparam int MAX_WIDTH_LIMIT = 2048;
  localparam int MAX_HEIGHT      = 4096;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;

  localparam int APB_DW      = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } pem_reg_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } pem_sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } pem_sqrt_rsp_t;

endpackage

`default_nettype wire

// File: hdl/pem_stream_if.sv
// ---------------------------------------------------------------------------
// pem stream interfaces
// valid/ready channels for incoming pixels and outgoing edge results
// ---------------------------------------------------------------------------
`default_nettype none

interface pem_pix_if;
  import pem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

interface pem_edge_if;
  import pem_pkg::*;

  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] edge_value;
  logic [COL_W-1:0]  center_column;
  logic [ROW_W-1:0]  center_row;
  logic              frame_last;

  modport source (output valid, edge_value, center_column, center_row, frame_last,
                  input ready);
  modport sink   (input valid, edge_value, center_column, center_row, frame_last,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/pem_line_store.sv
// ---------------------------------------------------------------------------
// pem_line_store
// single-port line memory holding the upper and middle grey of each column
// ---------------------------------------------------------------------------
`default_nettype none

module pem_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  input  logic [2*pem_pkg::GREY_W-1:0] wdata,
  output logic [2*pem_pkg::GREY_W-1:0] rdata
);
  import pem_pkg::*;

  // upper grey in the high byte, middle grey in the low byte
  logic [2*GREY_W-1:0] mem [DEPTH];
  logic [2*GREY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/pem_isqrt.sv
// ---------------------------------------------------------------------------
// pem_isqrt
// iterative ceiling square root, one result bit per cycle plus a rounding step
// ---------------------------------------------------------------------------
`default_nettype none

module pem_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pem_pkg::pem_sqrt_req_t req,
  output pem_pkg::pem_sqrt_rsp_t rsp
);
  import pem_pkg::*;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'b001,
    SQ_STEP  = 3'b010,
    SQ_ROUND = 3'b100
  } sq_state_t;

  sq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ROOT_W-1:0]   s_r, s_nxt;
  logic [RAD_W-1:0]    m_r, m_nxt;
  logic                done_r, done_nxt;

  logic [ROOT_W-1:0]   bit_mask;
  logic [ROOT_W-1:0]   cand;
  logic [2*ROOT_W-1:0] cand_sq;
  logic [2*ROOT_W-1:0] m_ext;

  assign bit_mask = ROOT_W'(1) << cnt_r;
  // the rounding step squares the floor root itself
  assign cand     = (state_r == SQ_ROUND) ? s_r : (s_r | bit_mask);
  assign cand_sq  = cand * cand;
  assign m_ext    = (2*ROOT_W)'(m_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    m_nxt     = m_r;
    done_nxt  = 1'b0;
    case (state_r)
      SQ_IDLE: begin
        if (req.start) begin
          state_nxt = SQ_STEP;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          s_nxt     = '0;
          m_nxt     = req.radicand;
        end
      end
      SQ_STEP: begin
        if (cand_sq <= m_ext) begin
          s_nxt = cand;
        end
        if (cnt_r == '0) begin
          state_nxt = SQ_ROUND;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      SQ_ROUND: begin
        if (cand_sq < m_ext) begin
          s_nxt = s_r + ROOT_W'(1);
        end
        done_nxt  = 1'b1;
        state_nxt = SQ_IDLE;
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    s_r   <= s_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = s_r;

endmodule

`default_nettype wire

// File: hdl/prewitt_edge_magnitude.sv
// an interior pixel goes from the grey register through the window, gradient, square,
//   root start and bit-serial square root (11 steps plus rounding) states to the result
//   register; a new pixel is taken only once the block is back in its idle state
// the result register lets the next pixel in while a result waits downstream
// reset (rst_n low, synchronous): counters, window and handshakes clear,
//   frame_width back to 640 and frame_height to 480; line memory is not cleared
// ---------------------------------------------------------------------------
// prewitt_edge_magnitude
// streaming 3x3 prewitt edge detector on grey levels of bgr pixels
// ---------------------------------------------------------------------------
`default_nettype none

module prewitt_edge_magnitude #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pem_pix_if.sink                       in_pix,
  pem_edge_if.source                    out_edge,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pem_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pem_pkg::APB_DW-1:0]    pwdata,
  output logic [pem_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import pem_pkg::*;

  localparam int LS_AW      = $clog2(MAX_LINE_PIXELS);
  localparam int LINE_LIMIT = (MAX_LINE_PIXELS < MAX_WIDTH_LIMIT) ? MAX_LINE_PIXELS
                                                                  : MAX_WIDTH_LIMIT;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WIN   = 7'b0000010,
    S_GRAD  = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_START = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [WID_W-1:0]         width_r, width_nxt;
  logic [HGT_W-1:0]         height_r, height_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [GREY_W-1:0]        grey_r, grey_nxt;
  logic [GREY_W-1:0]        win_r [WIN_N];
  logic [GREY_W-1:0]        win_nxt [WIN_N];
  logic [COL_W-1:0]         rcol_r, rcol_nxt;
  logic [ROW_W-1:0]         rrow_r, rrow_nxt;
  logic                     rlast_r, rlast_nxt;
  logic signed [GRAD_W-1:0] vx_r, vx_nxt;
  logic signed [GRAD_W-1:0] vy_r, vy_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt;
  logic [SQ_W-1:0]          sqy_r, sqy_nxt;
  logic [GREY_W-1:0]        edge_r, edge_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [GREY_W-1:0]        out_value_r, out_value_nxt;
  logic [COL_W-1:0]         out_col_r, out_col_nxt;
  logic [ROW_W-1:0]         out_row_r, out_row_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     accept;
  logic                     cfg_we;
  pem_reg_t                 reg_sel;
  logic [WID_W-1:0]         eff_w;
  logic [HGT_W-1:0]         eff_h;
  logic [WID_W-1:0]         col_inc;
  logic [HGT_W-1:0]         row_inc;
  logic [SUM_W-1:0]         pix_sum;
  logic [PROD3_W-1:0]       pix_prod;
  logic [SUM_W-1:0]         sum_right, sum_left, sum_bottom, sum_top;
  logic signed [2*GRAD_W-1:0] prod_x, prod_y;
  logic                     slot_free;

  logic                     ls_en, ls_we;
  logic [LS_AW-1:0]         ls_addr;
  logic [2*GREY_W-1:0]      ls_wdata, ls_rdata;
  logic [GREY_W-1:0]        ls_upper, ls_middle;

  pem_sqrt_req_t            sq_req;
  pem_sqrt_rsp_t            sq_rsp;

  assign accept = in_pix.valid && in_pix.ready;
  assign cfg_we = psel && penable && pwrite;
  assign reg_sel = pem_reg_t'(paddr[REG_SEL_BIT]);
  assign pready = 1'b1;

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  // effective frame size, out-of-range settings clamped
  always_comb begin
    eff_w = width_r;
    if (width_r < WID_W'(MIN_DIM)) begin
      eff_w = WID_W'(MIN_DIM);
    end else if (width_r > WID_W'(LINE_LIMIT)) begin
      eff_w = WID_W'(LINE_LIMIT);
    end
    eff_h = height_r;
    if (height_r < HGT_W'(MIN_DIM)) begin
      eff_h = HGT_W'(MIN_DIM);
    end else if (height_r > HGT_W'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end
  end

  assign col_inc = WID_W'(col_r) + WID_W'(1);
  assign row_inc = HGT_W'(row_r) + HGT_W'(1);

  assign pix_sum  = SUM_W'(in_pix.blue) + SUM_W'(in_pix.green) + SUM_W'(in_pix.red);
  assign pix_prod = PROD3_W'(pix_sum) * PROD3_W'(DIV3_MUL);

  assign sum_right  = SUM_W'(win_r[2]) + SUM_W'(win_r[5]) + SUM_W'(win_r[8]);
  assign sum_left   = SUM_W'(win_r[0]) + SUM_W'(win_r[3]) + SUM_W'(win_r[6]);
  assign sum_bottom = SUM_W'(win_r[6]) + SUM_W'(win_r[7]) + SUM_W'(win_r[8]);
  assign sum_top    = SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2]);

  assign prod_x = vx_r * vx_r;
  assign prod_y = vy_r * vy_r;

  assign ls_upper  = ls_rdata[2*GREY_W-1:GREY_W];
  assign ls_middle = ls_rdata[GREY_W-1:0];
  assign ls_en     = accept || (state_r == S_WIN);
  assign ls_we     = (state_r == S_WIN);
  assign ls_addr   = LS_AW'(col_r);
  // middle moves up, new grey becomes the middle line
  assign ls_wdata  = {ls_middle, grey_r};

  assign sq_req.start    = (state_r == S_START);
  assign sq_req.radicand = RAD_W'(sqx_r) + RAD_W'(sqy_r);

  assign slot_free = !out_valid_r || out_edge.ready;

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    grey_nxt      = grey_r;
    win_nxt       = win_r;
    rcol_nxt      = rcol_r;
    rrow_nxt      = rrow_r;
    rlast_nxt     = rlast_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    edge_nxt      = edge_r;
    out_valid_nxt = out_valid_r && !out_edge.ready;
    out_value_nxt = out_value_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          grey_nxt  = pix_prod[DIV3_SHIFT+GREY_W-1:DIV3_SHIFT];
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = ls_upper;
        win_nxt[3] = win_r[4];
        win_nxt[4] = win_r[5];
        win_nxt[5] = ls_middle;
        win_nxt[6] = win_r[7];
        win_nxt[7] = win_r[8];
        win_nxt[8] = grey_r;
        rcol_nxt   = col_r - COL_W'(1);
        rrow_nxt   = row_r - ROW_W'(1);
        rlast_nxt  = (WID_W'(col_r) == eff_w - WID_W'(1)) &&
                     (HGT_W'(row_r) == eff_h - HGT_W'(1));
        if (col_inc >= eff_w) begin
          col_nxt = '0;
          row_nxt = (row_inc >= eff_h) ? '0 : ROW_W'(row_inc);
        end else begin
          col_nxt = COL_W'(col_inc);
        end
        // window is complete once two rows and two columns have passed
        if (row_r >= ROW_W'(2) && col_r >= COL_W'(2)) begin
          state_nxt = S_GRAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GRAD: begin
        vx_nxt    = $signed(GRAD_W'(sum_right)) - $signed(GRAD_W'(sum_left));
        vy_nxt    = $signed(GRAD_W'(sum_bottom)) - $signed(GRAD_W'(sum_top));
        state_nxt = S_SQ;
      end
      S_SQ: begin
        sqx_nxt   = prod_x[SQ_W-1:0];
        sqy_nxt   = prod_y[SQ_W-1:0];
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sq_rsp.done) begin
          if (sq_rsp.root >= ROOT_W'(EDGE_MAX)) begin
            edge_nxt = '0;
          end else begin
            edge_nxt = GREY_W'(ROOT_W'(EDGE_MAX) - sq_rsp.root);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = edge_r;
          out_col_nxt   = rcol_r;
          out_row_nxt   = rrow_r;
          out_last_nxt  = rlast_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // any register write restarts the frame
    if (cfg_we) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  width_nxt  = pwdata[WID_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = pwdata[HGT_W-1:0];
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WID_W'(WIDTH_RESET);
      height_r    <= HGT_W'(HEIGHT_RESET);
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
    grey_r      <= grey_nxt;
    rcol_r      <= rcol_nxt;
    rrow_r      <= rrow_nxt;
    rlast_r     <= rlast_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    sqx_r       <= sqx_nxt;
    sqy_r       <= sqy_nxt;
    edge_r      <= edge_nxt;
    out_value_r <= out_value_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_last_r  <= out_last_nxt;
  end

  pem_line_store #(
    .DEPTH (MAX_LINE_PIXELS)
  ) u_line_store (
    .clk   (clk),
    .en    (ls_en),
    .we    (ls_we),
    .addr  (ls_addr),
    .wdata (ls_wdata),
    .rdata (ls_rdata)
  );

  pem_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign in_pix.ready           = (state_r == S_IDLE);
  assign out_edge.valid         = out_valid_r;
  assign out_edge.edge_value    = out_value_r;
  assign out_edge.center_column = out_col_r;
  assign out_edge.center_row    = out_row_r;
  assign out_edge.frame_last    = out_last_r;

endmodule

`default_nettype wire

// File: hdl/pem_checker.sv
// ---------------------------------------------------------------------------
// pem_checker
// port-level checks on the prewitt edge magnitude block, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "prewitt_edge_magnitude_assert.svh"

module pem_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pem_pkg::GREY_W-1:0]  out_edge_value,
  input wire logic [pem_pkg::COL_W-1:0]   out_center_column,
  input wire logic [pem_pkg::ROW_W-1:0]   out_center_row,
  input wire logic                        out_frame_last
);
  import pem_pkg::*;

  logic [GREY_W+COL_W+ROW_W:0] out_payload;

  assign out_payload = {out_edge_value, out_center_column, out_center_row, out_frame_last};

  // a pending result stays offered until taken
  `PEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a pending result keeps its payload
  `PEM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

  // one pixel at a time: ready drops right after a transaction
  `PEM_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready)

  // results only ever belong to interior pixels
  `PEM_ASSERT_SAME(a_out_interior, out_valid, out_center_column != '0 && out_center_row != '0)

endmodule

bind prewitt_edge_magnitude pem_checker u_pem_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_pix.valid),
  .in_ready          (in_pix.ready),
  .out_valid         (out_edge.valid),
  .out_ready         (out_edge.ready),
  .out_edge_value    (out_edge.edge_value),
  .out_center_column (out_edge.center_column),
  .out_center_row    (out_edge.center_row),
  .out_frame_last    (out_edge.frame_last)
);

`default_nettype wire
